[src/gufcd_pkg.sv]
package gufcd_pkg;

  localparam int COORD_W  = 9;
  localparam int GRID_MAX = (1 << COORD_W) - 1;
  localparam int NODE_W   = 2 * COORD_W;
  localparam int CELLS    = 1 << NODE_W;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [NODE_W-1:0]  node_t;

  localparam node_t  BORDER_NODE = '0;
  localparam coord_t GRID_RESET  = coord_t'(GRID_MAX);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_WALK,
    S_COMP,
    S_LINK,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    coord_t rows;
    coord_t cols;
  } grid_cfg_t;

  typedef struct packed {
    logic joined;
    logic last;
  } result_t;

endpackage

[src/gufcd_ram.sv]
module gufcd_ram import gufcd_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  node_t waddr,
  input  node_t wdata,
  input  logic  re,
  input  node_t raddr,
  output node_t rdata
);

  node_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/gufcd_border.sv]
module gufcd_border import gufcd_pkg::*; (
  input  node_t     node,
  input  logic      neg,
  input  grid_cfg_t grid,
  output logic      border
);

  coord_t row;
  coord_t col;

  assign row = node[NODE_W-1:COORD_W];
  assign col = node[COORD_W-1:0];

  // a point on row/col zero, or at or past the last row/col, is the border node
  assign border = neg || (row == '0) || (col == '0) ||
                  (row >= grid.rows) || (col >= grid.cols);

endmodule

[src/gufcd_seq.sv]
module gufcd_seq import gufcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  grid_cfg_t grid,
  input  logic      in_valid,
  output logic      in_ready,
  input  coord_t    start_row,
  input  coord_t    start_col,
  input  coord_t    end_row,
  input  coord_t    end_col,
  input  logic      out_free,
  output logic      emit,
  output result_t   result
);

  seq_state_t state_r, state_nxt;

  coord_t x1_r, y1_r, x2_r, y2_r;
  coord_t x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic   kind_r, kind_nxt;
  logic   phase_r, phase_nxt;
  logic   col_pend_r, col_pend_nxt;
  logic   joined_r, joined_nxt;
  node_t  cur_r, cur_nxt;
  node_t  start_r, start_nxt;
  node_t  root_r, root_nxt;
  node_t  ra_r, ra_nxt;
  node_t  clr_cnt_r, clr_cnt_nxt;

  logic   ram_we, ram_re;
  node_t  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  node_t  brd_node;
  logic   brd_neg, brd;

  coord_t min_x, min_y;
  node_t  pt_a, pt_b, pt;
  logic   b_neg, pt_neg;

  node_t  walk_root;
  logic   walk_stop, comp_stop;
  logic   accept, row_eq, col_eq;

  gufcd_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gufcd_border u_border (
    .node   (brd_node),
    .neg    (brd_neg),
    .grid   (grid),
    .border (brd)
  );

  // union operands: the segment's lower-index end point and its neighbor one row or column lower
  always_comb begin
    min_x = (x1_r < x2_r) ? x1_r : x2_r;
    min_y = (y1_r < y2_r) ? y1_r : y2_r;
    if (!kind_r) begin
      pt_a  = {x1_r, min_y};
      pt_b  = {x1_r - coord_t'(1), min_y};
      b_neg = (x1_r == '0);
    end else begin
      pt_a  = {min_x, y1_r};
      pt_b  = {min_x, y1_r - coord_t'(1)};
      b_neg = (y1_r == '0);
    end
    pt     = phase_r ? pt_b : pt_a;
    pt_neg = phase_r && b_neg;
  end

  always_comb begin
    if (state_r == S_WALK || state_r == S_COMP) begin
      brd_node = ram_rdata;
      brd_neg  = 1'b0;
    end else begin
      brd_node = pt;
      brd_neg  = pt_neg;
    end
  end

  assign walk_root = brd ? BORDER_NODE : cur_r;
  assign walk_stop = brd || (ram_rdata == cur_r);
  assign comp_stop = brd || (ram_rdata == root_r);
  assign accept    = in_valid && in_ready;
  assign row_eq    = (start_row == end_row);
  assign col_eq    = (start_col == end_col);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept && (row_eq || col_eq)) state_nxt = S_START;
      end
      S_START: begin
        if (brd) state_nxt = phase_r ? S_LINK : S_START;
        else     state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_stop) begin
          if (start_r != walk_root) state_nxt = S_COMP;
          else                      state_nxt = phase_r ? S_LINK : S_START;
        end
      end
      S_COMP: begin
        if (comp_stop) state_nxt = phase_r ? S_LINK : S_START;
      end
      S_LINK: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = col_pend_r ? S_START : S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready  = 1'b0;
    emit      = 1'b0;
    result    = '{joined: joined_r, last: !col_pend_r};
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = root_r;
    ram_re    = 1'b0;
    ram_raddr = pt;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clr_cnt_r;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_START: begin
        ram_re    = !brd;
        ram_raddr = pt;
      end
      S_WALK: begin
        ram_re    = 1'b1;
        ram_raddr = walk_stop ? start_r : ram_rdata;
      end
      S_COMP: begin
        // rewrite this node to the root, then follow its old parent
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = root_r;
        ram_re    = !comp_stop;
        ram_raddr = ram_rdata;
      end
      S_LINK: begin
        ram_we    = (ra_r != root_r);
        ram_waddr = (ra_r == BORDER_NODE) ? root_r : ra_r;
        ram_wdata = (ra_r == BORDER_NODE) ? BORDER_NODE : root_r;
      end
      S_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    x1_nxt       = x1_r;
    y1_nxt       = y1_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    kind_nxt     = kind_r;
    phase_nxt    = phase_r;
    col_pend_nxt = col_pend_r;
    joined_nxt   = joined_r;
    cur_nxt      = cur_r;
    start_nxt    = start_r;
    root_nxt     = root_r;
    ra_nxt       = ra_r;
    clr_cnt_nxt  = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + node_t'(1);
      end
      S_IDLE: begin
        if (accept) begin
          x1_nxt       = start_row;
          y1_nxt       = start_col;
          x2_nxt       = end_row;
          y2_nxt       = end_col;
          kind_nxt     = !row_eq;
          phase_nxt    = 1'b0;
          col_pend_nxt = row_eq && col_eq;
        end
      end
      S_START: begin
        if (brd) begin
          root_nxt  = BORDER_NODE;
          ra_nxt    = phase_r ? ra_r : BORDER_NODE;
          phase_nxt = 1'b1;
        end else begin
          cur_nxt   = pt;
          start_nxt = pt;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          root_nxt = walk_root;
          cur_nxt  = start_r;
          if (start_r == walk_root) begin
            ra_nxt    = phase_r ? ra_r : walk_root;
            phase_nxt = 1'b1;
          end
        end else begin
          cur_nxt = ram_rdata;
        end
      end
      S_COMP: begin
        cur_nxt = ram_rdata;
        if (comp_stop) begin
          ra_nxt    = phase_r ? ra_r : root_r;
          phase_nxt = 1'b1;
        end
      end
      S_LINK: begin
        joined_nxt = (ra_r != root_r);
      end
      S_EMIT: begin
        if (out_free && col_pend_r) begin
          col_pend_nxt = 1'b0;
          kind_nxt     = 1'b1;
          phase_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      col_pend_r <= 1'b0;
      phase_r    <= 1'b0;
      kind_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      col_pend_r <= col_pend_nxt;
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r     <= x1_nxt;
    y1_r     <= y1_nxt;
    x2_r     <= x2_nxt;
    y2_r     <= y2_nxt;
    joined_r <= joined_nxt;
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
  end

endmodule

[src/grid_union_find_cycle_detect.sv]
// Disjoint-set engine over the points of a grid of up to 512 x 512 points, border points
// merged into one node. Each segment transaction gives one union when its rows match, one
// when its columns match, two (row union first) for a single point, and none otherwise;
// each result says whether two sets were joined, with tlast on the last one of the segment.
// A union's time grows with the parent reads of the two root searches (none for a border
// point) and with the nodes rewritten by path compression, plus any wait for a free output
// register. in_tready is high only between items, and a pending result in the output
// register does not block the next segment. After reset a clearing pass writes each of the
// 262144 parent memory entries with its own index, with in_tready low; configuration
// writes are taken at any time but belong between items.
module grid_union_find_cycle_detect import gufcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // start_row, start_col, end_row, end_col, zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // joined, zero pad
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coord_t               cfg_data
);

  grid_cfg_t grid_r;
  logic      out_valid_r;
  result_t   out_res_r;
  logic      out_free;
  logic      emit;
  result_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r.rows <= GRID_RESET;
      grid_r.cols <= GRID_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_GRID_ROWS) grid_r.rows <= cfg_data;
      if (cfg_index == REG_GRID_COLS) grid_r.cols <= cfg_data;
    end
  end

  gufcd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid      (grid_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_row (in_tdata[COORD_W-1:0]),
    .start_col (in_tdata[2*COORD_W-1:COORD_W]),
    .end_row   (in_tdata[3*COORD_W-1:2*COORD_W]),
    .end_col   (in_tdata[4*COORD_W-1:3*COORD_W]),
    .out_free  (out_free),
    .emit      (emit),
    .result    (result)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-1){1'b0}}, out_res_r.joined};
  assign out_tlast  = out_res_r.last;

endmodule

[src/gufcd_checker.sv]
module gufcd_checker import gufcd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_W-1:0]      in_tdata,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata,
  input logic                 out_tlast,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input coord_t               cfg_data
);

  // reset starts the clearing pass and empties the output register
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block ready or result valid right after reset");

  // a segment that causes a union keeps the block busy in the next cycle
  a_union_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    ((in_tdata[COORD_W-1:0] == in_tdata[3*COORD_W-1:2*COORD_W]) ||
     (in_tdata[2*COORD_W-1:COORD_W] == in_tdata[4*COORD_W-1:3*COORD_W]))
    |=> !in_tready)
    else $error("ready again right after a segment with a union");

  // a result still waiting while ready is high must close its segment
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tready |-> out_tlast)
    else $error("block idle while a non-final result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result transaction changed");

endmodule

bind grid_union_find_cycle_detect gufcd_checker u_gufcd_checker (.*);
